// ===== sv/i2cm_pkg.sv =====
// Shared types, constants and phase tables of the I2C master byte engine.
package i2cm_pkg;

	localparam int unsigned TICK_W  = 16;
	localparam int unsigned PHASE_W = 5;
	localparam int unsigned SUB_W   = 2;

	localparam logic [TICK_W-1:0] PHASE_TICKS_RESET = 16'd360;

	localparam logic [PHASE_W-1:0] WR_DATA_PHASES = 5'd24;
	localparam logic [PHASE_W-1:0] WR_ACK_RELEASE = 5'd25;
	localparam logic [PHASE_W-1:0] WR_ACK_SAMPLE  = 5'd26;
	localparam logic [PHASE_W-1:0] RD_DATA_PHASES = 5'd16;
	localparam logic [PHASE_W-1:0] RD_ACK_DRIVE   = 5'd17;
	localparam logic [PHASE_W-1:0] RD_ACK_HIGH    = 5'd18;

	localparam logic [SUB_W-1:0] SUB_SCL_LOW  = 2'd0;
	localparam logic [SUB_W-1:0] SUB_SDA_SET  = 2'd1;
	localparam logic [SUB_W-1:0] SUB_SCL_HIGH = 2'd2;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_STOP  = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		logic scl_we;
		logic scl_val;
		logic sda_we;
		logic sda_val;
	} lvl_upd_t;

	typedef struct packed {
		logic       cmd_valid;
		op_t        op;
		logic [7:0] tx_byte;
		logic       send_nack;
		logic       sda_in;
	} in_beat_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_bit;
	} res_t;

	function automatic logic [PHASE_W-1:0] phase_total(input op_t op);
		logic [PHASE_W-1:0] n;
		unique case (op)
			OP_START: n = 5'd3;
			OP_STOP:  n = 5'd4;
			OP_WRITE: n = 5'd28;
			OP_READ:  n = 5'd20;
			default:  n = 5'd3;
		endcase
		return n;
	endfunction

endpackage

// ===== sv/i2cm_phase_dec.sv =====
// Bus level updates applied on entry to a phase of a command.
module i2cm_phase_dec (
	input  i2cm_pkg::op_t                   op,
	input  logic [i2cm_pkg::PHASE_W-1:0]    idx,
	input  logic [i2cm_pkg::SUB_W-1:0]      sub,
	input  logic                            data_msb,
	input  logic                            nack,
	output i2cm_pkg::lvl_upd_t              upd
);

	always_comb begin
		upd = '0;
		unique case (op)
			i2cm_pkg::OP_START: begin
				if (idx == 5'd0) begin
					upd = '{scl_we: 1'b1, scl_val: 1'b1, sda_we: 1'b1, sda_val: 1'b1};
				end else if (idx == 5'd1) begin
					upd.sda_we = 1'b1;
				end else begin
					upd.scl_we = 1'b1;
				end
			end
			i2cm_pkg::OP_STOP: begin
				if (idx == 5'd0) begin
					upd.scl_we = 1'b1;
				end else if (idx == 5'd1) begin
					upd.sda_we = 1'b1;
				end else if (idx == 5'd2) begin
					upd.scl_we  = 1'b1;
					upd.scl_val = 1'b1;
				end else begin
					upd.sda_we  = 1'b1;
					upd.sda_val = 1'b1;
				end
			end
			i2cm_pkg::OP_WRITE: begin
				if (idx < i2cm_pkg::WR_DATA_PHASES) begin
					if (sub == i2cm_pkg::SUB_SCL_LOW) begin
						upd.scl_we = 1'b1;
					end else if (sub == i2cm_pkg::SUB_SDA_SET) begin
						upd.sda_we  = 1'b1;
						upd.sda_val = data_msb;
					end else begin
						upd.scl_we  = 1'b1;
						upd.scl_val = 1'b1;
					end
				end else if (idx == i2cm_pkg::WR_ACK_RELEASE) begin
					upd.sda_we  = 1'b1;
					upd.sda_val = 1'b1;
				end else if (idx == i2cm_pkg::WR_ACK_SAMPLE) begin
					upd.scl_we  = 1'b1;
					upd.scl_val = 1'b1;
				end else begin
					upd.scl_we = 1'b1;
				end
			end
			i2cm_pkg::OP_READ: begin
				if (idx < i2cm_pkg::RD_DATA_PHASES) begin
					upd.scl_we = 1'b1;
					if (!idx[0]) begin
						if (idx == 5'd0) begin
							upd.sda_we  = 1'b1;
							upd.sda_val = 1'b1;
						end
					end else begin
						upd.scl_val = 1'b1;
					end
				end else if (idx == i2cm_pkg::RD_ACK_DRIVE) begin
					upd.sda_we  = 1'b1;
					upd.sda_val = nack;
				end else if (idx == i2cm_pkg::RD_ACK_HIGH) begin
					upd.scl_we  = 1'b1;
					upd.scl_val = 1'b1;
				end else begin
					upd.scl_we = 1'b1;
				end
			end
			default: upd = '0;
		endcase
	end

endmodule

// ===== sv/i2cm_core.sv =====
// Command sequencer: phase and tick counters, shift register and bus levels.
module i2cm_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step_en,
	input  logic [i2cm_pkg::TICK_W-1:0]   phase_ticks,
	input  i2cm_pkg::in_beat_t            beat,
	output i2cm_pkg::res_t                res
);

	i2cm_pkg::op_t                  active_op_q;
	logic                           running_q;
	logic [i2cm_pkg::PHASE_W-1:0]   phase_q;
	logic [i2cm_pkg::SUB_W-1:0]     sub_q;
	logic [i2cm_pkg::TICK_W-1:0]    tick_q;
	logic [7:0]                     shift_q;
	logic                           nack_q;
	logic [7:0]                     rx_hold_q;
	logic                           ack_hold_q;
	logic                           scl_q;
	logic                           sda_q;

	logic                           start;
	i2cm_pkg::op_t                  op_e;
	logic [i2cm_pkg::PHASE_W-1:0]   phase_e;
	logic [i2cm_pkg::SUB_W-1:0]     sub_e;
	logic [i2cm_pkg::TICK_W-1:0]    tick_e;
	logic [7:0]                     shift_e;
	logic                           nack_e;
	logic                           scl_e;
	logic                           sda_e;
	logic                           run_e;
	logic [i2cm_pkg::TICK_W-1:0]    limit;
	logic [i2cm_pkg::TICK_W-1:0]    tick_inc;
	logic                           phase_end;
	logic [7:0]                     shift_lv;
	logic                           ack_lv;
	logic [i2cm_pkg::PHASE_W-1:0]   phase_inc;
	logic [i2cm_pkg::SUB_W-1:0]     sub_inc;
	i2cm_pkg::lvl_upd_t             upd_start;
	i2cm_pkg::lvl_upd_t             upd_next;

	i2cm_pkg::op_t                  active_op_n;
	logic                           running_n;
	logic [i2cm_pkg::PHASE_W-1:0]   phase_n;
	logic [i2cm_pkg::SUB_W-1:0]     sub_n;
	logic [i2cm_pkg::TICK_W-1:0]    tick_n;
	logic [7:0]                     shift_n;
	logic [7:0]                     rx_hold_n;
	logic                           ack_hold_n;
	logic                           scl_n;
	logic                           sda_n;
	logic                           done;

	i2cm_phase_dec u_dec_start (
		.op       (beat.op),
		.idx      ('0),
		.sub      (i2cm_pkg::SUB_SCL_LOW),
		.data_msb (beat.tx_byte[7]),
		.nack     (beat.send_nack),
		.upd      (upd_start)
	);

	i2cm_phase_dec u_dec_next (
		.op       (op_e),
		.idx      (phase_inc),
		.sub      (sub_inc),
		.data_msb (shift_lv[7]),
		.nack     (nack_e),
		.upd      (upd_next)
	);

	// Take a new command when idle, then run the leave side of the current phase.
	always_comb begin
		start   = ~running_q & beat.cmd_valid;
		op_e    = start ? beat.op        : active_op_q;
		phase_e = start ? '0             : phase_q;
		sub_e   = start ? '0             : sub_q;
		tick_e  = start ? '0             : tick_q;
		shift_e = start ? beat.tx_byte   : shift_q;
		nack_e  = start ? beat.send_nack : nack_q;
		run_e   = running_q | start;
		scl_e   = (start && upd_start.scl_we) ? upd_start.scl_val : scl_q;
		sda_e   = (start && upd_start.sda_we) ? upd_start.sda_val : sda_q;

		limit     = (phase_ticks == '0) ? {{(i2cm_pkg::TICK_W-1){1'b0}}, 1'b1} : phase_ticks;
		tick_inc  = tick_e + 1'b1;
		phase_end = run_e && (tick_inc >= limit);
		phase_inc = phase_e + 1'b1;
		sub_inc   = (sub_e == i2cm_pkg::SUB_SCL_HIGH) ? i2cm_pkg::SUB_SCL_LOW : sub_e + 1'b1;

		shift_lv = shift_e;
		ack_lv   = ack_hold_q;
		if (phase_end) begin
			if (op_e == i2cm_pkg::OP_WRITE) begin
				if (phase_e < i2cm_pkg::WR_DATA_PHASES && sub_e == i2cm_pkg::SUB_SCL_HIGH) begin
					shift_lv = {shift_e[6:0], 1'b0};
				end else if (phase_e == i2cm_pkg::WR_ACK_SAMPLE) begin
					ack_lv = beat.sda_in;
				end
			end else if (op_e == i2cm_pkg::OP_READ) begin
				if (phase_e < i2cm_pkg::RD_DATA_PHASES && phase_e[0]) begin
					shift_lv = {shift_e[6:0], beat.sda_in};
				end
			end
		end
	end

	// Advance to the next phase or finish the command.
	always_comb begin
		active_op_n = op_e;
		running_n   = run_e;
		phase_n     = phase_e;
		sub_n       = sub_e;
		tick_n      = tick_e;
		shift_n     = shift_lv;
		rx_hold_n   = rx_hold_q;
		ack_hold_n  = ack_lv;
		scl_n       = scl_e;
		sda_n       = sda_e;
		done        = 1'b0;
		if (run_e) begin
			if (phase_end) begin
				tick_n = '0;
				if (phase_inc >= i2cm_pkg::phase_total(op_e)) begin
					if (op_e == i2cm_pkg::OP_READ) begin
						rx_hold_n = shift_lv;
						sda_n     = 1'b1;
					end
					running_n = 1'b0;
					phase_n   = '0;
					done      = 1'b1;
				end else begin
					phase_n = phase_inc;
					sub_n   = sub_inc;
					if (upd_next.scl_we) begin
						scl_n = upd_next.scl_val;
					end
					if (upd_next.sda_we) begin
						sda_n = upd_next.sda_val;
					end
				end
			end else begin
				tick_n = tick_inc;
			end
		end

		res.scl_out  = scl_e;
		res.sda_out  = sda_e;
		res.busy_res = run_e;
		res.done_res = done;
		res.rx_byte  = rx_hold_n;
		res.ack_bit  = ack_hold_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_op_q <= i2cm_pkg::OP_START;
			running_q   <= 1'b0;
			phase_q     <= '0;
			sub_q       <= '0;
			tick_q      <= '0;
			shift_q     <= '0;
			nack_q      <= 1'b0;
			rx_hold_q   <= '0;
			ack_hold_q  <= 1'b0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
		end else if (step_en) begin
			active_op_q <= active_op_n;
			running_q   <= running_n;
			phase_q     <= phase_n;
			sub_q       <= sub_n;
			tick_q      <= tick_n;
			shift_q     <= shift_n;
			nack_q      <= nack_e;
			rx_hold_q   <= rx_hold_n;
			ack_hold_q  <= ack_hold_n;
			scl_q       <= scl_n;
			sda_q       <= sda_n;
		end
	end

endmodule

// ===== sv/i2c_master_byte_engine_top.sv =====
// Top level of the I2C master byte engine: input register, sequencer, result register.
//
// Usage:
//   Each slave-side beat is one tick of the bus time base. tuser carries the
//   command flag and opcode, tdata the byte to send, the ACK/NACK choice for a
//   read and the sampled SDA level. Each beat yields exactly one master-side
//   beat with the SCL/SDA drive levels of that tick, busy and done flags, the
//   byte of the last read and the acknowledge of the last write.
//   cfg_we/cfg_wdata write phase_ticks, the ticks per bus phase (0 acts as 1);
//   write it only while no command runs and no beat is in flight.
// Throughput:
//   One beat per cycle while the result slot is free or draining. A beat taken
//   at a clock edge lands in the input register, is worked by the sequencer and
//   is loaded into the result register, which drives the master side.
// Reset:
//   arst_n clears both pipeline stages, puts the bus levels at idle (both
//   lines released), the sequencer idle and phase_ticks at 360.
// Stall:
//   When the receiver holds tready low the result register holds its beat; the
//   input register still takes one more beat, then s_axis_tready drops until
//   the result is taken. No beat is lost or repeated.
module i2c_master_byte_engine_top (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,          // phase_ticks

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,       // [7:0] tx_byte, [8] send_nack, [9] sda_in, rest 0
	input  logic [2:0]  s_axis_tuser,       // [0] cmd_valid, [2:1] op

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata        // [0] scl_out, [1] sda_out, [2] busy_res,
	                                        // [3] done_res, [11:4] rx_byte, [12] ack_bit, rest 0
);

	logic [i2cm_pkg::TICK_W-1:0] phase_ticks_q;

	logic                        valid_s1;
	i2cm_pkg::in_beat_t          beat_s1;
	logic                        out_valid_q;
	i2cm_pkg::res_t              res_q;
	i2cm_pkg::res_t              res;

	logic                        in_take;
	logic                        advance;

	// Advance the sequencer one tick whenever a beat waits and the result slot is free or draining.
	assign advance       = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | advance;
	assign in_take       = s_axis_tvalid & s_axis_tready;

	// Hold the configured phase length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= i2cm_pkg::PHASE_TICKS_RESET;
		end else if (cfg_we) begin
			phase_ticks_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			beat_s1.cmd_valid <= s_axis_tuser[0];
			beat_s1.op        <= i2cm_pkg::op_t'(s_axis_tuser[2:1]);
			beat_s1.tx_byte   <= s_axis_tdata[7:0];
			beat_s1.send_nack <= s_axis_tdata[8];
			beat_s1.sda_in    <= s_axis_tdata[9];
		end
	end

	i2cm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (advance),
		.phase_ticks (phase_ticks_q),
		.beat        (beat_s1),
		.res         (res)
	);

	// Result register: load on advance, drop once the receiver takes the beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, res_q.ack_bit, res_q.rx_byte, res_q.done_res,
	                        res_q.busy_res, res_q.sda_out, res_q.scl_out};

endmodule

// ===== tb/i2c_master_byte_engine_top_tb.sv =====
// Self-checking testbench for the I2C master byte engine: tick-level commands against a predictor.
`timescale 1ns / 100ps

module i2c_master_byte_engine_top_tb;

	// ------------------------------------------------------------------
	// Clock, reset and the block's ports
	// ------------------------------------------------------------------
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;     // [7:0] tx_byte, [8] send_nack, [9] sda_in, rest 0
	logic [2:0]  s_tuser = '0;     // [0] cmd_valid, [2:1] op
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;          // [0] scl, [1] sda, [2] busy, [3] done, [11:4] rx, [12] ack

	always #4 clk = ~clk;

	i2c_master_byte_engine_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata)
	);

	// ------------------------------------------------------------------
	// Shared bookkeeping
	// ------------------------------------------------------------------
	i2cm_pkg::in_beat_t tick_q[$];        // ticks waiting to be offered to the block
	i2cm_pkg::res_t     bus_expect_q[$];  // predicted per-tick bus state, oldest first
	bit          tick_taken = 1'b0;
	bit          calm = 1'b0;      // suppress random idling on both sides
	int unsigned err_count = 0;
	int unsigned beats_checked = 0;
	int unsigned cmd_issued[4] = '{0, 0, 0, 0};
	int unsigned cmd_total = 0;
	int unsigned ticks_planned = 0;
	logic [15:0] plan_len = i2cm_pkg::PHASE_TICKS_RESET;  // phase length the planner assumes
	int unsigned stall_left = 0;
	bit          stall_done = 1'b0;

	// ------------------------------------------------------------------
	// Predictor state: its own copy of the engine and of phase_ticks
	// ------------------------------------------------------------------
	logic [15:0] phase_len = i2cm_pkg::PHASE_TICKS_RESET;
	i2cm_pkg::op_t eng_op = i2cm_pkg::OP_START;
	logic        eng_busy = 1'b0;
	logic [4:0]  eng_phase = '0;
	logic [15:0] eng_tick = '0;
	logic [7:0]  eng_shift = '0;
	logic        eng_nack = 1'b0;
	logic [7:0]  last_rx = '0;
	logic        last_ack = 1'b0;
	logic        bus_scl = 1'b1;
	logic        bus_sda = 1'b1;

	// Number of bus phases each command takes.
	function automatic int unsigned op_phase_count(input i2cm_pkg::op_t op);
		case (op)
			i2cm_pkg::OP_START: return 3;
			i2cm_pkg::OP_STOP:  return 4;
			i2cm_pkg::OP_WRITE: return 28;
			default:            return 20;
		endcase
	endfunction

	// Line levels set on entry to a phase.
	function automatic void drive_levels(input logic [4:0] idx);
		case (eng_op)
			i2cm_pkg::OP_START: begin
				if (idx == 0) begin
					bus_scl = 1'b1;
					bus_sda = 1'b1;
				end else if (idx == 1)
					bus_sda = 1'b0;
				else
					bus_scl = 1'b0;
			end
			i2cm_pkg::OP_STOP: begin
				if (idx == 0)      bus_scl = 1'b0;
				else if (idx == 1) bus_sda = 1'b0;
				else if (idx == 2) bus_scl = 1'b1;
				else               bus_sda = 1'b1;
			end
			i2cm_pkg::OP_WRITE: begin
				// eight bits of low / data / high, then the acknowledge clock
				if (idx < 24) begin
					case (idx % 3)
						0:       bus_scl = 1'b0;
						1:       bus_sda = eng_shift[7];
						default: bus_scl = 1'b1;
					endcase
				end else if (idx == 25)
					bus_sda = 1'b1;
				else if (idx == 26)
					bus_scl = 1'b1;
				else
					bus_scl = 1'b0;
			end
			default: begin
				// release SDA with the first clock low, answer after the eighth bit
				if (idx < 16) begin
					bus_scl = idx[0];
					if (idx == 0) bus_sda = 1'b1;
				end else if (idx == 17)
					bus_sda = eng_nack;
				else if (idx == 18)
					bus_scl = 1'b1;
				else
					bus_scl = 1'b0;
			end
		endcase
	endfunction

	// Sampling done in the last tick of a phase.
	function automatic void sample_bus(input logic [4:0] idx, input logic sda);
		if (eng_op == i2cm_pkg::OP_WRITE) begin
			if (idx < 24 && idx % 3 == 2) eng_shift = {eng_shift[6:0], 1'b0};
			else if (idx == 26)           last_ack = sda;
		end else if (eng_op == i2cm_pkg::OP_READ) begin
			if (idx < 16 && idx[0]) eng_shift = {eng_shift[6:0], sda};
		end
	endfunction

	// Advance the engine by one tick and return the bus state of that tick.
	function automatic i2cm_pkg::res_t step_engine(input i2cm_pkg::in_beat_t b);
		i2cm_pkg::res_t r;
		logic [15:0]    lim;
		lim = (phase_len == 0) ? 16'd1 : phase_len;
		if (!eng_busy && b.cmd_valid) begin
			eng_op    = b.op;
			eng_shift = b.tx_byte;
			eng_nack  = b.send_nack;
			eng_phase = '0;
			eng_tick  = '0;
			eng_busy  = 1'b1;
			drive_levels(5'd0);
		end
		r.scl_out  = bus_scl;
		r.sda_out  = bus_sda;
		r.busy_res = eng_busy;
		r.done_res = 1'b0;
		if (eng_busy) begin
			eng_tick = eng_tick + 16'd1;
			if (eng_tick >= lim) begin
				sample_bus(eng_phase, b.sda_in);
				eng_phase = eng_phase + 5'd1;
				eng_tick  = '0;
				if (eng_phase >= op_phase_count(eng_op)) begin
					if (eng_op == i2cm_pkg::OP_READ) begin
						last_rx = eng_shift;
						bus_sda = 1'b1;
					end
					eng_busy   = 1'b0;
					eng_phase  = '0;
					r.done_res = 1'b1;
				end else
					drive_levels(eng_phase);
			end
		end
		r.rx_byte = last_rx;
		r.ack_bit = last_ack;
		return r;
	endfunction

	task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] seen);
		if (seen !== want) begin
			err_count++;
			if (err_count <= 40)
				$display("%0t: %s expected %0h actual %0h", $time, what, want, seen);
		end
	endtask

	// ------------------------------------------------------------------
	// Input side: offer queued ticks, changing at the falling edge
	// ------------------------------------------------------------------
	always @(negedge clk) begin : feed_ticks
		i2cm_pkg::in_beat_t nb;
		if (arst_n && (!s_tvalid || tick_taken)) begin
			if (tick_q.size() != 0 && (calm || $urandom_range(99) >= 8)) begin
				nb = tick_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {6'b0, nb.sda_in, nb.send_nack, nb.tx_byte};
				s_tuser  <= {nb.op, nb.cmd_valid};
			end else
				s_tvalid <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Output side: ready with random gaps and one long hold-off
	// ------------------------------------------------------------------
	always @(negedge clk) begin : drain_results
		if (arst_n) begin
			// hold off once while the sender still has plenty queued, so both
			// pipeline stages fill and the input side stalls
			if (!stall_done && tick_q.size() > 10 && beats_checked > 20) begin
				stall_left = 400;
				stall_done = 1'b1;
			end
			if (stall_left != 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else
				m_tready <= calm || $urandom_range(99) >= 8;
		end
	end

	// ------------------------------------------------------------------
	// Rising edge: predict every accepted tick, check every result beat
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch_bus
		i2cm_pkg::in_beat_t tb_in;
		i2cm_pkg::res_t     want;
		i2cm_pkg::res_t     got;
		if (arst_n) begin
			if (cfg_we) phase_len = cfg_wdata;
			tick_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				tb_in.cmd_valid = s_tuser[0];
				tb_in.op        = i2cm_pkg::op_t'(s_tuser[2:1]);
				tb_in.tx_byte   = s_tdata[7:0];
				tb_in.send_nack = s_tdata[8];
				tb_in.sda_in    = s_tdata[9];
				bus_expect_q.push_back(step_engine(tb_in));
			end
			if (m_tvalid && m_tready) begin
				got.scl_out  = m_tdata[0];
				got.sda_out  = m_tdata[1];
				got.busy_res = m_tdata[2];
				got.done_res = m_tdata[3];
				got.rx_byte  = m_tdata[11:4];
				got.ack_bit  = m_tdata[12];
				if (bus_expect_q.size() == 0) begin
					err_count++;
					$display("%0t: result beat with nothing expected, actual %0h", $time, m_tdata);
				end else begin
					want = bus_expect_q.pop_front();
					beats_checked++;
					check_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
					check_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
					check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
					check_field("done_res", 8'(want.done_res), 8'(got.done_res));
					check_field("rx_byte", want.rx_byte, got.rx_byte);
					check_field("ack_bit", 8'(want.ack_bit), 8'(got.ack_bit));
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus planning
	// ------------------------------------------------------------------
	function automatic i2cm_pkg::in_beat_t filler_tick();
		i2cm_pkg::in_beat_t b;
		b.cmd_valid = 1'b0;
		b.op        = i2cm_pkg::op_t'($urandom_range(3));
		b.tx_byte   = 8'($urandom);
		b.send_nack = 1'($urandom);
		b.sda_in    = 1'($urandom);
		return b;
	endfunction

	function automatic int unsigned pick_gap();
		return ($urandom_range(9) == 0) ? $urandom_range(20) : $urandom_range(3);
	endfunction

	// Queue one command and the ticks it runs for, then gap idle ticks. While
	// the command runs, sprinkle ignored commands; poke_last puts one on the
	// completion tick.
	task automatic issue_cmd(input i2cm_pkg::op_t op, input logic [7:0] data, input logic nack,
			input int unsigned gap, input bit poke_last);
		int unsigned        span;
		i2cm_pkg::in_beat_t b;
		span = op_phase_count(op) * ((plan_len == 0) ? 1 : plan_len);
		b = filler_tick();
		b.cmd_valid = 1'b1;
		b.op        = op;
		b.tx_byte   = data;
		b.send_nack = nack;
		tick_q.push_back(b);
		for (int unsigned i = 1; i < span + gap; i++) begin
			b = filler_tick();
			if (i < span && ($urandom_range(99) < 4 || (poke_last && i == span - 1)))
				b.cmd_valid = 1'b1;
			tick_q.push_back(b);
		end
		ticks_planned += span + gap;
		cmd_issued[op]++;
		cmd_total++;
	endtask

	// Hold until every tick is taken and every result is back; look a little
	// after the falling edge so the driver's update of that edge is visible.
	task automatic wait_quiet();
		while (tick_q.size() != 0 || s_tvalid || bus_expect_q.size() != 0) begin
			@(negedge clk);
			#1;
		end
	endtask

	task automatic set_phase_len(input logic [15:0] v);
		wait_quiet();
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		plan_len = v;
	endtask

	// Mostly well-formed transfers: start, address, one data byte, stop; the
	// rest is commands in arbitrary order.
	task automatic run_transfer();
		bit rd;
		if ($urandom_range(99) < 15) begin
			repeat ($urandom_range(4, 1))
				issue_cmd(i2cm_pkg::op_t'($urandom_range(3)), 8'($urandom), 1'($urandom),
					pick_gap(), $urandom_range(19) == 0);
		end else begin
			rd = 1'($urandom);
			issue_cmd(i2cm_pkg::OP_START, 8'($urandom), 1'($urandom), pick_gap(), 1'b0);
			issue_cmd(i2cm_pkg::OP_WRITE, {7'($urandom), rd}, 1'($urandom), pick_gap(), 1'b0);
			if (rd)
				issue_cmd(i2cm_pkg::OP_READ, 8'($urandom), 1'b1, pick_gap(), 1'b0);
			else
				issue_cmd(i2cm_pkg::OP_WRITE, 8'($urandom), 1'($urandom), pick_gap(), 1'b0);
			// repeated start now and then
			if ($urandom_range(9) == 0)
				issue_cmd(i2cm_pkg::OP_START, 8'($urandom), 1'($urandom), pick_gap(), 1'b0);
			issue_cmd(i2cm_pkg::OP_STOP, 8'($urandom), 1'($urandom), pick_gap(), 1'b0);
		end
	endtask

	initial begin : stimulus
		logic [15:0] rand_lens[3];
		int unsigned target;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Zero phase length acts as one; ignored commands on the completion tick.
		set_phase_len(16'd0);
		issue_cmd(i2cm_pkg::OP_START, 8'h00, 1'b0, 0, 1'b1);
		issue_cmd(i2cm_pkg::OP_WRITE, 8'hFF, 1'b0, 0, 1'b1);
		issue_cmd(i2cm_pkg::OP_READ, 8'hFF, 1'b1, 0, 1'b1);
		issue_cmd(i2cm_pkg::OP_STOP, 8'h00, 1'b0, 0, 1'b0);

		set_phase_len(16'd1);
		issue_cmd(i2cm_pkg::OP_START, 8'h00, 1'b0, 0, 1'b0);
		issue_cmd(i2cm_pkg::OP_WRITE, 8'h5A, 1'b0, 1, 1'b0);
		issue_cmd(i2cm_pkg::OP_READ, 8'h00, 1'b0, 0, 1'b0);
		issue_cmd(i2cm_pkg::OP_READ, 8'h00, 1'b1, 0, 1'b0);
		issue_cmd(i2cm_pkg::OP_STOP, 8'hFF, 1'b1, 0, 1'b0);

		// Random transfers over short phase lengths; the first setting runs
		// with no idling on either side.
		rand_lens = '{16'd2, 16'd1, 16'd1};
		foreach (rand_lens[k]) begin
			set_phase_len(rand_lens[k]);
			calm = (k == 0);
			target = ticks_planned + 60;
			while (ticks_planned < target) begin
				run_transfer();
				// sometimes let everything come back before going on
				if ($urandom_range(9) == 0) wait_quiet();
			end
		end
		wait_quiet();
		calm = 1'b0;

		repeat (10) @(negedge clk);
		$display("Covered %0d commands (start %0d, stop %0d, write %0d, read %0d) in %0d ticks",
			cmd_total, cmd_issued[i2cm_pkg::OP_START], cmd_issued[i2cm_pkg::OP_STOP],
			cmd_issued[i2cm_pkg::OP_WRITE], cmd_issued[i2cm_pkg::OP_READ], ticks_planned);
		$display("at phase lengths 0, 1 and 2 with one long receiver hold-off; %0d beats checked.",
			beats_checked);
		if (bus_expect_q.size() != 0) begin
			err_count++;
			$display("%0t: %0d expected result beats never arrived", $time, bus_expect_q.size());
		end
		if (err_count == 0)
			$display("i2c_master_byte_engine_top: match");
		else
			$display("i2c_master_byte_engine_top: mismatch");
		$finish;
	end

	// Guard against a hung handshake: far beyond the slowest correct run.
	initial begin : watchdog
		#200_000;
		$display("i2c_master_byte_engine_top: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
sv/i2cm_pkg.sv
sv/i2cm_phase_dec.sv
sv/i2cm_core.sv
sv/i2c_master_byte_engine_top.sv
tb/i2c_master_byte_engine_top_tb.sv
